// File: hw/rtl/mfir_pkg.sv
// Shared types, widths and tap constants for the multichannel 5-tap FIR low-pass.
// No dependencies; every other file in hw/rtl imports this package.
package mfir_pkg;

  localparam int LEADS       = 8;
  localparam int SAMPLE_BITS = 24;

  localparam int LEAD_W    = 3;
  localparam int TAP_COUNT = 5;
  localparam int PTR_W     = 3;
  localparam int IDX_W     = (LEADS > 1) ? $clog2(LEADS) : 1;

  localparam int TAP_W = 16;
  localparam logic signed [TAP_W-1:0] TAP_EDGE = TAP_W'(-2590);
  localparam logic signed [TAP_W-1:0] TAP_NEAR = TAP_W'(14977);
  localparam logic signed [TAP_W-1:0] TAP_MID  = TAP_W'(12353);

  localparam int LP_DIVISOR = 36500;

  localparam int PAIR_W = SAMPLE_BITS + 1;
  localparam int PROD_W = SAMPLE_BITS + TAP_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int Q_W    = SAMPLE_BITS;
  localparam int FILT_W = SAMPLE_BITS + 1;

  // |tap sum| < 2^(SAMPLE_BITS+15); the magnitude is split into two halves
  // so the reciprocal multiply runs as four narrow partial products
  localparam int HALF_W      = (SAMPLE_BITS + 17) / 2;
  localparam int MAG_W       = 2 * HALF_W;
  localparam int MID_W       = MAG_W + 2;
  localparam int SUM_W       = MAG_W + 1;
  // shift wide enough that the rounded-up reciprocal stays exact over the range
  localparam int RECIP_SHIFT = MAG_W + 15;
  localparam int POST_SHIFT  = RECIP_SHIFT - MAG_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(LP_DIVISOR) - 64'd1) / 64'(LP_DIVISOR);
  localparam logic [MAG_W-1:0]  LP_RECIP = RECIP_FULL[MAG_W-1:0];
  localparam logic [HALF_W-1:0] RECIP_HI = LP_RECIP[MAG_W-1:HALF_W];
  localparam logic [HALF_W-1:0] RECIP_LO = LP_RECIP[HALF_W-1:0];

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [LEAD_W-1:0]             lead_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PTR_W-1:0]              ptr_t;

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic {
    HS_IDLE,
    HS_WRITE
  } hist_state_e;

  typedef struct packed {
    op_e     op;
    lead_t   lead;
    sample_t sample;
  } cmd_t;

  typedef struct packed {
    ptr_t                     ptr;
    sample_t [TAP_COUNT-1:0]  smp;
  } row_t;

  // x[0] is the newest sample, x[TAP_COUNT-1] the oldest
  typedef struct packed {
    lead_t                    lead;
    sample_t [TAP_COUNT-1:0]  x;
  } taps_t;

endpackage

// File: hw/rtl/mfir_if.sv
// Valid/ready channel interfaces for requests and filtered results.
// Depends on mfir_pkg for field types.
interface mfir_req_if import mfir_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    op;
  lead_t   lead;
  sample_t sample;

  modport source (output valid, op, lead, sample, input ready);
  modport sink   (input valid, op, lead, sample, output ready);
endinterface

interface mfir_rsp_if import mfir_pkg::*; ();
  logic                     valid;
  logic                     ready;
  lead_t                    lead_out;
  logic signed [FILT_W-1:0] filtered;

  modport source (output valid, lead_out, filtered, input ready);
  modport sink   (input valid, lead_out, filtered, output ready);
endinterface

// File: hw/rtl/mfir_front.sv
// Front end: accepts requests, drops out-of-range leads, queues commands.
// Depends on mfir_pkg and mfir_req_if.
module mfir_front import mfir_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfir_req_if.sink   req_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  cmd_t              q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              lead_ok;
  logic              push;
  logic              pop;
  cmd_t              cmd_in;

  assign req_i.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign lead_ok     = (int'(req_i.lead) < LEADS);
  // drop requests for leads that do not exist
  assign push        = req_i.valid && req_i.ready && lead_ok;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    cmd_in.op     = op_e'(req_i.op);
    cmd_in.lead   = req_i.lead;
    cmd_in.sample = req_i.sample;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: hw/rtl/mfir_hist.sv
// Back end, first half: per-lead history memory with read-modify-write.
// Depends on mfir_pkg; feeds ordered tap samples to mfir_dp.
module mfir_hist import mfir_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_valid_i,
  output logic  cmd_ready_o,
  input  cmd_t  cmd_i,
  output logic  taps_valid_o,
  input  logic  taps_ready_i,
  output taps_t taps_o
);

  hist_state_e      state_q, state_d;
  cmd_t             cur_q, cur_d;
  row_t             row_mem [LEADS];
  row_t             rd_row_q;
  logic             rd_vld_q;
  row_t             old_row;
  row_t             new_row;
  logic [LEADS-1:0] row_vld_q, row_vld_d;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] cmd_idx;
  logic [IDX_W-1:0] cur_idx;
  ptr_t             ptr_old;

  assign cmd_idx = IDX_W'(cmd_i.lead);
  assign cur_idx = IDX_W'(cur_q.lead);

  // a row without its valid bit reads as the cleared state
  always_comb begin
    ptr_t tap_idx;
    old_row          = rd_vld_q ? rd_row_q : '0;
    ptr_old          = (old_row.ptr >= PTR_W'(TAP_COUNT)) ? '0 : old_row.ptr;
    new_row          = old_row;
    new_row.smp[ptr_old] = cur_q.sample;
    new_row.ptr      = (ptr_old == PTR_W'(TAP_COUNT - 1)) ? '0 : ptr_old + PTR_W'(1);
    taps_o.lead      = cur_q.lead;
    for (int i = 0; i < TAP_COUNT; i++) begin
      // walk back from the newest entry, wrapping below zero
      tap_idx = (ptr_old >= PTR_W'(i)) ? ptr_old - PTR_W'(i)
                                       : ptr_old + PTR_W'(TAP_COUNT - i);
      taps_o.x[i] = new_row.smp[tap_idx];
    end
  end

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    row_vld_d    = row_vld_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    cmd_ready_o  = 1'b0;
    taps_valid_o = 1'b0;
    case (state_q)
      HS_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_CLEAR) begin
            row_vld_d[cmd_idx] = 1'b0;
          end else begin
            rd_en   = 1'b1;
            cur_d   = cmd_i;
            state_d = HS_WRITE;
          end
        end
      end
      HS_WRITE: begin
        taps_valid_o = 1'b1;
        // hold the row until the datapath takes the taps
        if (taps_ready_i) begin
          wr_en              = 1'b1;
          row_vld_d[cur_idx] = 1'b1;
          state_d            = HS_IDLE;
        end
      end
      default: begin
        state_d = HS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= HS_IDLE;
      row_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      row_vld_q <= row_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_row_q <= row_mem[cmd_idx];
      rd_vld_q <= row_vld_q[cmd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem[cur_idx] <= new_row;
    end
  end

  a_filter_goes_to_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == HS_IDLE && cmd_valid_i && cmd_i.op == OP_FILTER) |=> state_q == HS_WRITE)
    else $error("filter command did not start a row update");

  a_stall_holds_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == HS_WRITE && !taps_ready_i) |=> (state_q == HS_WRITE && $stable(cur_q)))
    else $error("pending row update changed while stalled");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (new_row.ptr < PTR_W'(TAP_COUNT)))
    else $error("write pointer left its range");

  a_clear_drops_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == HS_IDLE && cmd_valid_i && cmd_i.op == OP_CLEAR)
      |=> !row_vld_q[$past(cmd_idx)])
    else $error("clear did not invalidate the lead's row");

endmodule

// File: hw/rtl/mfir_dp.sv
// Back end, second half: symmetric tap multiply, sum, and division by the gain
// constant through a pipelined reciprocal multiply, truncating toward zero.
// Depends on mfir_pkg and mfir_rsp_if.
module mfir_dp import mfir_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       taps_valid_i,
  output logic       taps_ready_o,
  input  taps_t      taps_i,
  mfir_rsp_if.source rsp_o
);

  logic                     en;

  logic                     s1_vld_q;
  lead_t                    s1_lead_q;
  logic signed [PAIR_W-1:0] s1_edge_q, s1_edge_d;
  logic signed [PAIR_W-1:0] s1_near_q, s1_near_d;
  sample_t                  s1_mid_q;

  logic                     s2_vld_q;
  lead_t                    s2_lead_q;
  logic signed [PROD_W-1:0] s2_pe_q, s2_pe_d;
  logic signed [PROD_W-1:0] s2_pn_q, s2_pn_d;
  logic signed [PROD_W-1:0] s2_pm_q, s2_pm_d;

  logic                     s3_vld_q;
  lead_t                    s3_lead_q;
  logic signed [ACC_W-1:0]  s3_acc_q, s3_acc_d;

  logic                     dv_vld_q;
  lead_t                    dv_lead_q;
  logic                     dv_neg_q;
  logic [MAG_W-1:0]         dv_mag_q, dv_mag_d;

  logic                     mu_vld_q;
  lead_t                    mu_lead_q;
  logic                     mu_neg_q;
  logic [MAG_W-1:0]         mu_hh_q, mu_hh_d;
  logic [MAG_W-1:0]         mu_hl_q, mu_hl_d;
  logic [MAG_W-1:0]         mu_lh_q, mu_lh_d;
  logic [MAG_W-1:0]         mu_ll_q, mu_ll_d;

  logic                     md_vld_q;
  lead_t                    md_lead_q;
  logic                     md_neg_q;
  logic [MAG_W-1:0]         md_hh_q;
  logic [MID_W-1:0]         md_mid_q, md_mid_d;

  logic                     qt_vld_q;
  lead_t                    qt_lead_q;
  logic                     qt_neg_q;
  logic [SUM_W-1:0]         qt_sum;
  logic [Q_W-1:0]           qt_quo_q, qt_quo_d;

  logic [FILT_W-1:0]        quo_ext;
  logic                     out_vld_q;
  lead_t                    out_lead_q;
  logic signed [FILT_W-1:0] out_filt_q, out_filt_d;

  // advance the whole pipeline only when the output register can move
  assign en           = !out_vld_q || rsp_o.ready;
  assign taps_ready_o = en;

  always_comb begin
    s1_edge_d = PAIR_W'($signed(taps_i.x[0])) + PAIR_W'($signed(taps_i.x[TAP_COUNT-1]));
    s1_near_d = PAIR_W'($signed(taps_i.x[1])) + PAIR_W'($signed(taps_i.x[TAP_COUNT-2]));
    s2_pe_d   = PROD_W'(s1_edge_q) * PROD_W'(TAP_EDGE);
    s2_pn_d   = PROD_W'(s1_near_q) * PROD_W'(TAP_NEAR);
    s2_pm_d   = PROD_W'(s1_mid_q) * PROD_W'(TAP_MID);
    s3_acc_d  = ACC_W'(s2_pe_q) + ACC_W'(s2_pn_q) + ACC_W'(s2_pm_q);
    // split into sign and magnitude for the divider
    dv_mag_d  = s3_acc_q[ACC_W-1] ? MAG_W'(-s3_acc_q) : MAG_W'(s3_acc_q);
    // magnitude times reciprocal as four half-width products
    mu_hh_d   = MAG_W'(dv_mag_q[MAG_W-1:HALF_W]) * MAG_W'(RECIP_HI);
    mu_hl_d   = MAG_W'(dv_mag_q[MAG_W-1:HALF_W]) * MAG_W'(RECIP_LO);
    mu_lh_d   = MAG_W'(dv_mag_q[HALF_W-1:0]) * MAG_W'(RECIP_HI);
    mu_ll_d   = MAG_W'(dv_mag_q[HALF_W-1:0]) * MAG_W'(RECIP_LO);
    // drop the low half of the low product; it cannot carry past the middle
    md_mid_d  = MID_W'(mu_hl_q) + MID_W'(mu_lh_q) + MID_W'(mu_ll_q[MAG_W-1:HALF_W]);
    qt_sum    = SUM_W'(md_hh_q) + SUM_W'(md_mid_q[MID_W-1:HALF_W]);
    qt_quo_d  = qt_sum[POST_SHIFT +: Q_W];
    quo_ext   = {1'b0, qt_quo_q};
    out_filt_d = qt_neg_q ? -$signed(quo_ext) : $signed(quo_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      dv_vld_q  <= 1'b0;
      mu_vld_q  <= 1'b0;
      md_vld_q  <= 1'b0;
      qt_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= taps_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      dv_vld_q  <= s3_vld_q;
      mu_vld_q  <= dv_vld_q;
      md_vld_q  <= mu_vld_q;
      qt_vld_q  <= md_vld_q;
      out_vld_q <= qt_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_lead_q  <= taps_i.lead;
      s1_edge_q  <= s1_edge_d;
      s1_near_q  <= s1_near_d;
      s1_mid_q   <= taps_i.x[2];
      s2_lead_q  <= s1_lead_q;
      s2_pe_q    <= s2_pe_d;
      s2_pn_q    <= s2_pn_d;
      s2_pm_q    <= s2_pm_d;
      s3_lead_q  <= s2_lead_q;
      s3_acc_q   <= s3_acc_d;
      dv_lead_q  <= s3_lead_q;
      dv_neg_q   <= s3_acc_q[ACC_W-1];
      dv_mag_q   <= dv_mag_d;
      mu_lead_q  <= dv_lead_q;
      mu_neg_q   <= dv_neg_q;
      mu_hh_q    <= mu_hh_d;
      mu_hl_q    <= mu_hl_d;
      mu_lh_q    <= mu_lh_d;
      mu_ll_q    <= mu_ll_d;
      md_lead_q  <= mu_lead_q;
      md_neg_q   <= mu_neg_q;
      md_hh_q    <= mu_hh_q;
      md_mid_q   <= md_mid_d;
      qt_lead_q  <= md_lead_q;
      qt_neg_q   <= md_neg_q;
      qt_quo_q   <= qt_quo_d;
      out_lead_q <= qt_lead_q;
      out_filt_q <= out_filt_d;
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.lead_out = out_lead_q;
  assign rsp_o.filtered = out_filt_q;

  a_div_input_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q |-> !dv_mag_q[MAG_W-1])
    else $error("tap sum too large for the divider width");

  a_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_vld_q |-> (qt_sum[SUM_W-1:POST_SHIFT+Q_W] == '0))
    else $error("quotient does not fit its width");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({s1_vld_q, s2_vld_q, s3_vld_q, dv_vld_q, mu_vld_q, md_vld_q,
                     qt_vld_q, out_vld_q}))
    else $error("pipeline moved while the output was stalled");

endmodule

// File: hw/rtl/multichannel_fir_lowpass_5tap.sv
// Multichannel 5-tap FIR low-pass: per-lead history, symmetric taps, gain 1/36500.
// A filter request holds the history unit through a row read, then a write-back that
// waits for the datapath to take the taps; a clear is done while idle. A result passes
// history read, three tap stages, four reciprocal-divide stages, output register.
// Reset clears all history rows at once through per-lead valid bits; no sweep.
// Depends on mfir_pkg, mfir_if, mfir_front, mfir_hist and mfir_dp.
module multichannel_fir_lowpass_5tap import mfir_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfir_req_if.sink   req_i,
  mfir_rsp_if.source rsp_o
);

  logic  cmd_valid;
  logic  cmd_ready;
  cmd_t  cmd;
  logic  taps_valid;
  logic  taps_ready;
  taps_t taps;

  mfir_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  mfir_hist u_hist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .taps_valid_o (taps_valid),
    .taps_ready_i (taps_ready),
    .taps_o       (taps)
  );

  mfir_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .taps_valid_i (taps_valid),
    .taps_ready_o (taps_ready),
    .taps_i       (taps),
    .rsp_o        (rsp_o)
  );

endmodule
